// File: hdl/dq_pkg.sv
package dq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int OCC_W    = 5;
    localparam int STATUS_W = 2;
    localparam int EXT_W    = 64;

    // m_axis_tdata layout, lowest bit first
    localparam int M_FRONT_LSB  = 0;
    localparam int M_BACK_LSB   = M_FRONT_LSB + VALUE_W;
    localparam int M_OCC_LSB    = M_BACK_LSB + VALUE_W;
    localparam int M_EMPTY_BIT  = M_OCC_LSB + OCC_W;
    localparam int M_FULL_BIT   = M_EMPTY_BIT + 1;
    localparam int M_STATUS_LSB = M_FULL_BIT + 1;
    localparam int M_USED_W     = M_STATUS_LSB + STATUS_W;
    localparam int M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY_POP = 2'd1,
        ST_FULL_PUSH = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } dq_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dq_stat_t;

endpackage

// File: hdl/dq_ram.sv
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hdl/dq_ctrl.sv
module dq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    output dq_pkg::dq_cmd_t  cmd,
    input  dq_pkg::dq_stat_t stat
);

    import dq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            // ends are read from the updated slots here
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/dq_datapath.sv
module dq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dq_pkg::dq_cmd_t                    cmd,
    output dq_pkg::dq_stat_t                   stat,
    input  logic [dq_pkg::OP_W-1:0]            op_in,
    input  logic signed [dq_pkg::VALUE_W-1:0]  value_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [dq_pkg::M_TDATA_W-1:0]       out_data
);

    import dq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] word_reg;
    logic [ADDR_W-1:0]     front_reg;
    logic [ADDR_W-1:0]     front_next;
    logic [ADDR_W-1:0]     back_reg;
    logic [ADDR_W-1:0]     back_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg;
    logic [M_TDATA_W-1:0]  out_data_next;

    logic signed [EXT_W-1:0]      value_ext;
    logic                         is_full;
    logic                         is_empty;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [ADDR_W-1:0]            front_prev;
    logic [ADDR_W-1:0]            back_succ;
    logic [ADDR_W-1:0]            front_succ;
    logic [ADDR_W-1:0]            back_prev;
    logic signed [DATA_WIDTH-1:0] rd_front;
    logic signed [DATA_WIDTH-1:0] rd_back;
    logic signed [EXT_W-1:0]      front_ext;
    logic signed [EXT_W-1:0]      back_ext;
    logic [EXT_W-1:0]             count_ext;

    assign value_ext = EXT_W'(value_in);

    // wrap slots modulo DEPTH, any DEPTH
    assign front_prev = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_succ = (front_reg == ADDR_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign back_prev  = (back_reg == '0) ? ADDR_W'(DEPTH - 1) : back_reg - 1'b1;
    assign back_succ  = (back_reg == ADDR_W'(DEPTH - 1)) ? '0 : back_reg + 1'b1;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = front_prev;
        if (cmd.exec)
        begin
            status_next = ST_DONE;
            case (op_reg)
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL_PUSH;
                    end
                    else
                    begin
                        front_next = front_prev;
                        ram_we     = 1'b1;
                        ram_waddr  = front_prev;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL_PUSH;
                    end
                    else
                    begin
                        back_next  = back_succ;
                        ram_we     = 1'b1;
                        ram_waddr  = back_succ;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY_POP;
                    end
                    else
                    begin
                        front_next = front_succ;
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY_POP;
                    end
                    else
                    begin
                        back_next  = back_prev;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (word_reg),
        .raddr_a (front_reg),
        .rdata_a (rd_front),
        .raddr_b (back_reg),
        .rdata_b (rd_back)
    );

    assign front_ext = EXT_W'(rd_front);
    assign back_ext  = EXT_W'(rd_back);
    assign count_ext = EXT_W'(count_reg);

    always_comb
    begin
        out_data_next = '0;
        if (!is_empty)
        begin
            out_data_next[M_FRONT_LSB +: VALUE_W] = front_ext[VALUE_W-1:0];
            out_data_next[M_BACK_LSB +: VALUE_W]  = back_ext[VALUE_W-1:0];
        end
        out_data_next[M_OCC_LSB +: OCC_W]       = count_ext[OCC_W-1:0];
        out_data_next[M_EMPTY_BIT]              = is_empty;
        out_data_next[M_FULL_BIT]               = is_full;
        out_data_next[M_STATUS_LSB +: STATUS_W] = status_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            back_reg      <= ADDR_W'(DEPTH - 1);
            count_reg     <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op_t'(op_in);
            word_reg <= value_ext[DATA_WIDTH-1:0];
        end
        if (cmd.load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule

// File: hdl/double_ended_queue.sv
// Double-ended queue over a ring of DEPTH words held in a two-read-port RAM.
// Each request carries an opcode on s_axis_tuser (push front, push back, pop
// front, pop back) and a signed 32-bit word on s_axis_tdata; every request
// gives exactly one result with the front and back words (zero when empty),
// the occupancy, empty and full flags and a status code (done, pop on empty
// ignored, push on full dropped). Words are stored as their low DATA_WIDTH
// bits and returned sign-extended. A request passes through capture, slot
// update with the RAM write, RAM read of both ends and output register
// load, which waits until the previous result has been taken. A new
// request is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset.
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // value[31:0]
    input  logic [dq_pkg::VALUE_W-1:0]      s_axis_tdata,
    // opcode[1:0]
    input  logic [dq_pkg::OP_W-1:0]         s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // front_value[31:0], back_value[63:32], occupancy[68:64], is_empty[69],
    // is_full[70], status[72:71], zero[79:73]
    output logic [dq_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    import dq_pkg::*;

    dq_cmd_t  cmd;
    dq_stat_t stat;

    dq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .stat          (stat)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .op_in     (s_axis_tuser),
        .value_in  ($signed(s_axis_tdata)),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
